[src/pairwise_edge_compatibility_macros.svh]
// ----------------------------------------------------------------------------
// pairwise_edge_compatibility_macros
// assertion macros shared by the edge compatibility rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_EDGE_COMPATIBILITY_MACROS_SVH
`define PAIRWISE_EDGE_COMPATIBILITY_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pec assertion failed");
// next-cycle implication
`define PEC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pec assertion failed");
`else
`define PEC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PEC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/pec_pkg.sv]
// ----------------------------------------------------------------------------
// pec_pkg
// shared types, constants and tables of the edge compatibility pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package pec_pkg;
	localparam int unsigned CORDIC_STEPS   = 16;
	localparam int unsigned CORDIC_PRESCALE = 12;
	localparam int unsigned CORDIC_LAT     = CORDIC_STEPS + 1;
	localparam int unsigned QUO_BITS       = 20;
	localparam int unsigned DIV_LAT        = QUO_BITS + 1;
	localparam int unsigned TAYLOR_TERMS   = 12;
	localparam int unsigned EXP_INT_LIMIT  = 12;
	localparam int unsigned POW_STEPS      = EXP_INT_LIMIT - 1;
	localparam int unsigned EXP_LAT        = 1 + 3 * TAYLOR_TERMS + POW_STEPS;

	localparam logic [15:0] HALF_TURN      = 16'h8000;
	localparam logic [16:0] QUARTER_TURN   = 17'd16384;
	localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
	localparam logic [28:0] EXP_M1_Q30     = 29'd395007542;
	localparam logic [15:0] RADIUS_RESET   = 16'd256;
	localparam logic [31:0] R2_RESET       = 32'(RADIUS_RESET) * 32'(RADIUS_RESET);

	typedef logic signed [16:0] diff_t;
	typedef logic signed [31:0] cord_t;
	typedef logic [30:0] q30_t;

	typedef struct packed {
		logic                ovf;
		logic [QUO_BITS-1:0] quo;
	} quo_t;

	function automatic logic [15:0] atan_turns(input logic [3:0] idx);
		logic [15:0] v;
		case (idx)
			4'd0:    v = 16'd8192;
			4'd1:    v = 16'd4836;
			4'd2:    v = 16'd2555;
			4'd3:    v = 16'd1297;
			4'd4:    v = 16'd651;
			4'd5:    v = 16'd326;
			4'd6:    v = 16'd163;
			4'd7:    v = 16'd81;
			4'd8:    v = 16'd41;
			4'd9:    v = 16'd20;
			4'd10:   v = 16'd10;
			4'd11:   v = 16'd5;
			4'd12:   v = 16'd3;
			4'd13:   v = 16'd1;
			4'd14:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

[src/pec_delay.sv]
// ----------------------------------------------------------------------------
// pec_delay
// shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
`default_nettype none
module pec_delay #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];
endmodule
`default_nettype wire

[src/pec_cordic.sv]
// ----------------------------------------------------------------------------
// pec_cordic
// pipelined vectoring cordic, one micro-rotation per stage, angle in turns
// ----------------------------------------------------------------------------
`default_nettype none
module pec_cordic import pec_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  diff_t       dx,
	input  diff_t       dy,
	output logic [15:0] phi
);
	cord_t       cx_s [CORDIC_STEPS+1];
	cord_t       cy_s [CORDIC_STEPS+1];
	logic [15:0] cz_s [CORDIC_STEPS+1];
	cord_t       x_pre;
	cord_t       y_pre;
	logic [15:0] z_pre;

	// fold the left half plane over
	always_comb begin
		x_pre = cord_t'(dx) <<< CORDIC_PRESCALE;
		y_pre = cord_t'(dy) <<< CORDIC_PRESCALE;
		z_pre = '0;
		if (dx < 0) begin
			x_pre = -x_pre;
			y_pre = -y_pre;
			z_pre = HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= x_pre;
			cy_s[0] <= y_pre;
			cz_s[0] <= z_pre;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] > 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + atan_turns(4'(i));
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - atan_turns(4'(i));
				end
			end
		end
	end

	assign phi = cz_s[CORDIC_STEPS];
endmodule
`default_nettype wire

[src/pec_div.sv]
// ----------------------------------------------------------------------------
// pec_div
// restoring divider, one quotient bit per stage, for dist2 * 2^23 / r^2
// ----------------------------------------------------------------------------
`default_nettype none
module pec_div import pec_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [33:0] dist2,
	input  logic [31:0] r2,
	output quo_t        quo
);
	logic [51:0]         rem_s [QUO_BITS+1];
	logic [QUO_BITS-1:0] q_s   [QUO_BITS+1];
	logic                ovf_s [QUO_BITS+1];

	// quotient reaches 2^20 or more: far outside the series range
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= {dist2, 3'b000} >= {5'b00000, r2};
			rem_s[0] <= {dist2[28:0], 23'd0};
			q_s[0]   <= '0;
		end
	end

	for (genvar s = 0; s < QUO_BITS; s++) begin : g_bit
		localparam int unsigned B = QUO_BITS - 1 - s;
		logic [51:0]         dvs;
		logic                take;
		logic [QUO_BITS-1:0] nq;

		always_comb begin
			dvs   = 52'(r2) << B;
			take  = rem_s[s] >= dvs;
			nq    = q_s[s];
			nq[B] = take;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1] <= take ? rem_s[s] - dvs : rem_s[s];
				q_s[s+1]   <= nq;
				ovf_s[s+1] <= ovf_s[s];
			end
		end
	end

	assign quo.ovf = ovf_s[QUO_BITS];
	assign quo.quo = q_s[QUO_BITS];
endmodule
`default_nettype wire

[src/pec_exp.sv]
// ----------------------------------------------------------------------------
// pec_exp
// exp(-a) in q1.30: taylor series on the fraction, then powers of exp(-1)
// ----------------------------------------------------------------------------
`default_nettype none
module pec_exp import pec_pkg::*; (
	input  logic clk,
	input  logic en,
	input  quo_t quo,
	output q30_t prox
);
	typedef struct packed {
		logic [29:0] y;
		logic [3:0]  n;
		logic        zero;
	} exp_ctl_t;

	q30_t     sum_a  [TAYLOR_TERMS+1];
	q30_t     term_a [TAYLOR_TERMS+1];
	exp_ctl_t ctl_a  [TAYLOR_TERMS+1];
	q30_t     sum_p  [POW_STEPS+1];
	exp_ctl_t ctl_p  [POW_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sum_a[0]       <= Q30_ONE;
			term_a[0]      <= Q30_ONE;
			ctl_a[0].y     <= {quo.quo[15:0], 14'd0};
			ctl_a[0].n     <= quo.quo[19:16];
			ctl_a[0].zero  <= quo.ovf || (quo.quo[19:16] >= 4'(EXP_INT_LIMIT));
		end
	end

	for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
		localparam int unsigned K     = k;
		localparam logic [32:0] RECIP = 33'(64'd4294967296 / K);
		logic [60:0] prod_s1;
		q30_t        sum_s1;
		exp_ctl_t    ctl_s1;
		logic [29:0] v_s2;
		logic [63:0] m_s2;
		q30_t        sum_s2;
		exp_ctl_t    ctl_s2;
		logic [29:0] q0;
		logic [29:0] rem;
		logic [29:0] nterm;

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1 <= 61'(term_a[k-1]) * 61'(ctl_a[k-1].y);
				sum_s1  <= sum_a[k-1];
				ctl_s1  <= ctl_a[k-1];
				v_s2    <= prod_s1[59:30];
				m_s2    <= 64'(prod_s1[59:30]) * 64'(RECIP);
				sum_s2  <= sum_s1;
				ctl_s2  <= ctl_s1;
			end
		end

		// reciprocal estimate is at most one short
		always_comb begin
			q0    = m_s2[61:32];
			rem   = v_s2 - 30'(q0 * 30'(K));
			nterm = (rem >= 30'(K)) ? q0 + 30'd1 : q0;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				term_a[k] <= {1'b0, nterm};
				sum_a[k]  <= (K % 2 == 1) ? sum_s2 - {1'b0, nterm} : sum_s2 + {1'b0, nterm};
				ctl_a[k]  <= ctl_s2;
			end
		end
	end

	assign sum_p[0] = sum_a[TAYLOR_TERMS];
	assign ctl_p[0] = ctl_a[TAYLOR_TERMS];

	for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
		logic [59:0] pw;

		assign pw = 60'(sum_p[j]) * 60'(EXP_M1_Q30);

		always_ff @(posedge clk) begin
			if (en) begin
				sum_p[j+1] <= (ctl_p[j].n > 4'(j)) ? 31'(pw >> 30) : sum_p[j];
				ctl_p[j+1] <= ctl_p[j];
			end
		end
	end

	assign prox = ctl_p[POW_STEPS].zero ? '0 : sum_p[POW_STEPS];
endmodule
`default_nettype wire

[src/pairwise_edge_compatibility.sv]
// Cocircularity compatibility of two oriented edges, one item per clock unless
// the output stalls. An item accepted on the slave side passes the proximity
// path, with the 17-stage cordic for the joining direction in parallel: three
// front stages, a 21-stage divider (one quotient bit per stage after the first),
// one setup stage, a 12-term series at three stages per term and 11 stages of
// exp(-1) powers, then two stages for the final product and saturation. The
// pipeline holds as a whole while the output register is full and not taken.
// The radius is squared at the write and takes effect the cycle after cfg_wr_en.
// ----------------------------------------------------------------------------
// pairwise_edge_compatibility
// top level: stream ports, radius register, angle terms and final product
// ----------------------------------------------------------------------------
`default_nettype none
`include "pairwise_edge_compatibility_macros.svh"
module pairwise_edge_compatibility import pec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_x, first_y, first_angle, second_x, second_y, second_angle
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// score
	output logic [15:0] m_axis_tdata,
	// coincident
	output logic        m_axis_tuser
);
	localparam int unsigned PHI_AT    = 1 + CORDIC_LAT;
	localparam int unsigned PROD_AT   = PHI_AT + 4;
	localparam int unsigned PROX_AT   = 3 + DIV_LAT + EXP_LAT;
	localparam int unsigned PROD_WAIT = PROX_AT - PROD_AT;
	localparam int unsigned FULL_AT   = PROX_AT + 1;

	logic               adv;
	logic [31:0]        r2_q;
	logic [FULL_AT-1:0] vld_q;
	logic               tvalid_q;
	logic [15:0]        score_q;
	logic               coinc_q;

	logic signed [15:0] fx, fy, sx, sy;
	diff_t              dx_s1, dy_s1;
	logic [31:0]        ang_s1;
	logic               coinc_s1;
	logic signed [33:0] sqx, sqy;
	logic [32:0]        sqx_s2, sqy_s2;
	logic [33:0]        dist2_s3;

	logic [15:0] phi;
	logic [31:0] ang_d;
	logic [15:0] u0, u1;
	logic [16:0] l0_s19, l1_s19;
	logic [16:0] lsum, del, d0, d1;
	logic [33:0] dsq;
	logic [16:0] c_s20, s0_s20, s1_s20;
	logic [33:0] cs_s21;
	logic [16:0] s1_s21;
	logic [32:0] prod_s22;
	logic [32:0] prod_d;

	quo_t        quo;
	q30_t        prox;
	logic        coinc_d;
	logic [63:0] full_s73;
	logic        coinc_s73;
	logic [17:0] sc;

	assign adv           = !tvalid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = score_q;
	assign m_axis_tuser  = coinc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= R2_RESET;
		end else if (cfg_wr_en) begin
			r2_q <= 32'(cfg_wr_data) * 32'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			tvalid_q <= 1'b0;
		end else if (adv) begin
			vld_q    <= {vld_q[FULL_AT-2:0], s_axis_tvalid};
			tvalid_q <= vld_q[FULL_AT-1];
		end
	end

	// front stages: differences, squares, squared distance
	assign fx = s_axis_tdata[15:0];
	assign fy = s_axis_tdata[31:16];
	assign sx = s_axis_tdata[63:48];
	assign sy = s_axis_tdata[79:64];
	assign sqx = 34'(dx_s1) * 34'(dx_s1);
	assign sqy = 34'(dy_s1) * 34'(dy_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= diff_t'(sx) - diff_t'(fx);
			dy_s1    <= diff_t'(sy) - diff_t'(fy);
			ang_s1   <= {s_axis_tdata[95:80], s_axis_tdata[47:32]};
			coinc_s1 <= (sx == fx) && (sy == fy);
			sqx_s2   <= sqx[32:0];
			sqy_s2   <= sqy[32:0];
			dist2_s3 <= 34'(sqx_s2) + 34'(sqy_s2);
		end
	end

	pec_cordic u_cordic (
		.clk (clk),
		.en  (adv),
		.dx  (dx_s1),
		.dy  (dy_s1),
		.phi (phi)
	);

	pec_delay #(.WIDTH(32), .DEPTH(CORDIC_LAT)) u_ang_dly (
		.clk  (clk),
		.en   (adv),
		.din  (ang_s1),
		.dout (ang_d)
	);

	// angle terms
	always_comb begin
		u0   = phi - ang_d[15:0];
		u1   = (phi + HALF_TURN) - ang_d[31:16];
		lsum = l0_s19 + l1_s19;
		del  = (lsum >= 17'(HALF_TURN)) ? lsum - 17'(HALF_TURN) : 17'(HALF_TURN) - lsum;
		dsq  = 34'(del) * 34'(del);
		d0   = (l0_s19 >= QUARTER_TURN) ? l0_s19 - QUARTER_TURN : QUARTER_TURN - l0_s19;
		d1   = (l1_s19 >= QUARTER_TURN) ? l1_s19 - QUARTER_TURN : QUARTER_TURN - l1_s19;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l0_s19   <= u0[15] ? 17'h10000 - 17'(u0) : 17'(u0);
			l1_s19   <= u1[15] ? 17'h10000 - 17'(u1) : 17'(u1);
			c_s20    <= 17'h10000 - dsq[30:14];
			s0_s20   <= {d0[14:0], 2'b00};
			s1_s20   <= {d1[14:0], 2'b00};
			cs_s21   <= 34'(c_s20) * 34'(s0_s20);
			s1_s21   <= s1_s20;
			prod_s22 <= 33'(35'(cs_s21[33:16]) * 35'(s1_s21));
		end
	end

	pec_delay #(.WIDTH(33), .DEPTH(PROD_WAIT)) u_prod_dly (
		.clk  (clk),
		.en   (adv),
		.din  (prod_s22),
		.dout (prod_d)
	);

	// proximity path
	pec_div u_div (
		.clk   (clk),
		.en    (adv),
		.dist2 (dist2_s3),
		.r2    (r2_q),
		.quo   (quo)
	);

	pec_exp u_exp (
		.clk  (clk),
		.en   (adv),
		.quo  (quo),
		.prox (prox)
	);

	pec_delay #(.WIDTH(1), .DEPTH(FULL_AT - 2)) u_coinc_dly (
		.clk  (clk),
		.en   (adv),
		.din  (coinc_s1),
		.dout (coinc_d)
	);

	// final product and saturation
	assign sc = full_s73[63:46];

	always_ff @(posedge clk) begin
		if (adv) begin
			full_s73  <= 64'(prod_d) * 64'(prox);
			coinc_s73 <= coinc_d;
			coinc_q   <= coinc_s73;
			if (coinc_s73) begin
				score_q <= '0;
			end else if (sc > 18'h0FFFF) begin
				score_q <= 16'hFFFF;
			end else begin
				score_q <= sc[15:0];
			end
		end
	end

	`PEC_ASSERT_IMP(a_coinc_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
	`PEC_ASSERT_IMP(a_r2_zero, clk, arst_n, m_axis_tvalid && (r2_q == '0), m_axis_tdata == '0)
	`PEC_ASSERT_IMP(a_prod_bound, clk, arst_n, vld_q[PROD_AT-1], prod_s22 <= 33'h1_0000_0000)
	`PEC_ASSERT_NXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(vld_q))
endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the edge compatibility pipeline: a queued stream
// driver, a predictor that scores each accepted pair, and a monitor that
// matches every result in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import pec_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	typedef struct packed {
		logic        coincident;
		logic [15:0] score;
	} compat_t;

	localparam int unsigned ARCTAN_STEP [16] = '{8192, 4836, 2555, 1297, 651, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0};
	localparam longint unsigned E_INV_Q30 = 64'd395007542;

	logic [95:0] pending_pairs[$];
	compat_t     expected_scores[$];
	logic [15:0] radius_now = 16'd256;
	logic        calm = 1'b0;
	int          errors = 0;
	int          results_seen = 0;

	pairwise_edge_compatibility dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] heading(input longint vx, input longint vy);
		longint x, y, xs, ys;
		logic [31:0] z;
		x = vx * 4096;
		y = vy * 4096;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'd32768;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_STEP[i];
			end
		end
		return z[15:0];
	endfunction

	function automatic longint unsigned turn_gap(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] u;
		u = a - b;
		return (u >= 16'h8000) ? 65536 - longint'(u) : longint'(u);
	endfunction

	function automatic longint unsigned decay_q30(input longint unsigned arg);
		longint unsigned n, y, sum, term;
		n = arg >> 16;
		y = (arg & 64'hFFFF) << 14;
		sum = 64'd1 << 30;
		term = 64'd1 << 30;
		if (n >= 12)
			return 0;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * y) >> 30) / k;
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		for (longint unsigned k = 0; k < n; k++)
			sum = (sum * E_INV_Q30) >> 30;
		return sum;
	endfunction

	function automatic compat_t score_pair(input logic [95:0] d, input logic [15:0] radius);
		longint dx, dy;
		longint unsigned l0, l1, del, c, s0, s1, dist2, r2, prox, prod, sc;
		logic [15:0] phi;
		compat_t r;
		dx = longint'($signed(d[63:48])) - longint'($signed(d[15:0]));
		dy = longint'($signed(d[79:64])) - longint'($signed(d[31:16]));
		r = '0;
		if (dx == 0 && dy == 0) begin
			r.coincident = 1'b1;
			return r;
		end
		phi = heading(dx, dy);
		l0 = turn_gap(phi, d[47:32]);
		l1 = turn_gap(phi + 16'h8000, d[95:80]);
		del = (l0 + l1 >= 32768) ? l0 + l1 - 32768 : 32768 - (l0 + l1);
		c = 65536 - ((del * del) >> 14);
		s0 = 4 * ((l0 >= 16384) ? l0 - 16384 : 16384 - l0);
		s1 = 4 * ((l1 >= 16384) ? l1 - 16384 : 16384 - l1);
		dist2 = longint'(dx * dx) + longint'(dy * dy);
		r2 = longint'(radius) * longint'(radius);
		prox = (r2 == 0) ? 0 : decay_q30((dist2 << 23) / r2);
		prod = ((c * s0) >> 16) * s1;
		sc = (prod * prox) >> 46;
		r.score = (sc > 65535) ? 16'hFFFF : sc[15:0];
		return r;
	endfunction

	// sender: records an expectation for every accepted item
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			expected_scores.push_back(score_pair(s_axis_tdata, radius_now));
		if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_pairs.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_pairs.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the pipeline up
	int  hold_left = 0;
	logic hold_done = 1'b0;
	always @(posedge clk) begin
		compat_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (expected_scores.size() == 0) begin
				$error("result with nothing expected: score %0d coincident %0d",
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = expected_scores.pop_front();
				if (m_axis_tdata !== want.score) begin
					$error("score: expected %0d, got %0d", want.score, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.coincident) begin
					$error("coincident: expected %0d, got %0d", want.coincident,
						m_axis_tuser);
					errors++;
				end
			end
		end
		if (!hold_done && results_seen == 20) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 23);
		end
	end

	function automatic logic [95:0] pack_pair(input logic [15:0] x0, y0, a0, x1, y1, a1);
		return {a1, y1, x1, a0, y0, x0};
	endfunction

	task automatic add_random(input int count);
		logic [15:0] x0, y0;
		for (int i = 0; i < count; i++) begin
			x0 = 16'($urandom);
			y0 = 16'($urandom);
			case ($urandom_range(9))
				0, 1: pending_pairs.push_back(pack_pair(x0, y0, 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom)));
				2: pending_pairs.push_back(pack_pair(x0, y0, 16'($urandom), x0, y0,
					16'($urandom)));
				default: pending_pairs.push_back(pack_pair(x0, y0, 16'($urandom),
					x0 + 16'($urandom_range(128)) - 16'd64,
					y0 + 16'($urandom_range(128)) - 16'd64, 16'($urandom)));
			endcase
		end
	endtask

	task automatic drain;
		while (pending_pairs.size() != 0 || s_axis_tvalid || expected_scores.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_radius(input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		radius_now = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed pairs at the reset radius
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		pending_pairs.push_back(pack_pair(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd0));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'd0, 16'd16, 16'd0, 16'h8000));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'h8000, 16'hFFF0, 16'd0, 16'd0));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'h4000, 16'd0, 16'd16, 16'hC000));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'hC000, 16'd0, 16'hFFF0, 16'h4000));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'h2000, 16'd8, 16'd8, 16'h6000));
		pending_pairs.push_back(pack_pair(16'h8000, 16'h8000, 16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF));
		pending_pairs.push_back(pack_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		pending_pairs.push_back(pack_pair(16'h7FFF, 16'h8000, 16'h1234, 16'h8000, 16'h7FFF, 16'hEDCB));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0));
		pending_pairs.push_back(pack_pair(16'd100, 16'd100, 16'h4000, 16'd100, 16'd100, 16'h0));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'd0, 16'd64, 16'd0, 16'h8000));
		add_random(110);
		drain();

		set_radius(16'd65535);
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'h8000));
		pending_pairs.push_back(pack_pair(16'd0, 16'd0, 16'h8000, 16'hFFFF, 16'd0, 16'd0));
		pending_pairs.push_back(pack_pair(16'h8000, 16'h8000, 16'd0, 16'h7FFF, 16'h7FFF, 16'd0));
		add_random(80);
		drain();

		set_radius(16'd1);
		calm = 1'b1;
		add_random(80);
		drain();
		calm = 1'b0;

		set_radius(16'd0);
		add_random(40);
		drain();

		set_radius(16'd4096);
		add_random(80);
		drain();

		set_radius(16'($urandom_range(65535, 1)));
		add_random(80);
		drain();

		set_radius(16'd64);
		add_random(60);
		drain();

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
